@@ rtl/ffa_pkg.sv @@
// shared types, constants and codes for the first-fit arena allocator
// used by ffa_cell and first_fit_arena_allocator_core; no dependencies
package ffa_pkg;

   localparam int ARENA_BYTES  = 65536;
   localparam int HEADER_BYTES = 24;
   localparam int MAX_BLOCKS   = 64;

   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int START_W = 16;
   localparam int LEN_W   = 17;
   localparam int END_W   = 18;
   localparam int TYPE_W  = 2;
   localparam int STAT_W  = 3;

   localparam int REQ_BITS   = TYPE_W + LEN_W + START_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = STAT_W + START_W + 1 + LEN_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [END_W-1:0]   HEADER_END  = END_W'(HEADER_BYTES);
   localparam logic [LEN_W-1:0]   HEADER_LEN  = LEN_W'(HEADER_BYTES);
   localparam logic [START_W-1:0] HEADER_ADDR = START_W'(HEADER_BYTES);
   localparam logic [END_W-1:0]   ARENA_END   = END_W'(ARENA_BYTES);
   localparam logic [LEN_W-1:0]   ARENA_LIMIT = LEN_W'(ARENA_BYTES);

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FREE    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_REALLOC = 2'd2;

   // result status
   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [STAT_W-1:0] ST_ZERO_SIZE  = 3'd3;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd4;

   // table edit operations broadcast to the cells
   localparam logic [1:0] EDIT_HOLD   = 2'd0;
   localparam logic [1:0] EDIT_INSERT = 2'd1;
   localparam logic [1:0] EDIT_DELETE = 2'd2;
   localparam logic [1:0] EDIT_UPDATE = 2'd3;

   typedef struct packed {
      logic [LEN_W-1:0]   size;
      logic [START_W-1:0] addr;
      logic [END_W-1:0]   need;
   } query_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [IDX_W-1:0]   index;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } edit_type;

   typedef struct packed {
      logic               fit_hit;
      logic [START_W-1:0] fit_pos;
      logic [IDX_W-1:0]   fit_slot;
      logic [END_W-1:0]   tail_end;
      logic               loc_hit;
      logic [IDX_W-1:0]   loc_idx;
      logic [LEN_W-1:0]   loc_len;
      logic               room_ok;
   } scan_type;

endpackage

@@ rtl/ffa_cell.sv @@
// one table cell: holds one block entry, shifts with its neighbors on edits
// and adds its own gap and match check to the scan word; uses ffa_pkg
module ffa_cell (
   input  logic                         clock,
   input  logic [ffa_pkg::IDX_W-1:0]    cell_index,
   input  logic [ffa_pkg::CNT_W-1:0]    count,
   input  ffa_pkg::query_type           query,
   input  ffa_pkg::edit_type            edit,
   input  logic [ffa_pkg::START_W-1:0]  left_start,
   input  logic [ffa_pkg::LEN_W-1:0]    left_len,
   input  logic [ffa_pkg::START_W-1:0]  right_start,
   input  logic [ffa_pkg::LEN_W-1:0]    right_len,
   input  ffa_pkg::scan_type            scan_in,
   output logic [ffa_pkg::START_W-1:0]  start_q,
   output logic [ffa_pkg::LEN_W-1:0]    len_q,
   output ffa_pkg::scan_type            scan_out
);

   logic [ffa_pkg::START_W-1:0] start_ff, start_in;
   logic [ffa_pkg::LEN_W-1:0]   len_ff, len_in;
   ffa_pkg::scan_type           scan_ff, scan_in_next;

   logic                        valid, has_next, fits, match, room_ok;
   logic [ffa_pkg::END_W-1:0]   prev_end, own_start, own_end;
   logic [ffa_pkg::LEN_W-1:0]   limit, addr_ext, room;

   always_comb begin
      valid     = ffa_pkg::CNT_W'(cell_index) < count;
      has_next  = (ffa_pkg::CNT_W'(cell_index) + ffa_pkg::CNT_W'(1)) < count;
      prev_end  = (cell_index == '0) ? '0
                : ffa_pkg::END_W'(left_start) + ffa_pkg::HEADER_END
                  + ffa_pkg::END_W'(left_len);
      own_start = ffa_pkg::END_W'(start_ff);
      own_end   = own_start + ffa_pkg::HEADER_END + ffa_pkg::END_W'(len_ff);
      fits      = (own_start >= prev_end) && ((own_start - prev_end) >= query.need);
      addr_ext  = ffa_pkg::LEN_W'(query.addr);
      match     = (ffa_pkg::LEN_W'(start_ff) + ffa_pkg::HEADER_LEN) == addr_ext;
      // in-place room runs to the next block's header or the arena end
      limit     = has_next ? ffa_pkg::LEN_W'(right_start) : ffa_pkg::ARENA_LIMIT;
      room      = (limit >= addr_ext) ? (limit - addr_ext) : '0;
      room_ok   = query.size <= room;
   end

   always_comb begin
      scan_in_next = scan_in;
      if (valid) begin
         scan_in_next.tail_end = own_end;
         if (!scan_in.fit_hit && fits) begin
            scan_in_next.fit_hit  = 1'b1;
            scan_in_next.fit_pos  = prev_end[ffa_pkg::START_W-1:0];
            scan_in_next.fit_slot = cell_index;
         end
         if (!scan_in.loc_hit && match) begin
            scan_in_next.loc_hit = 1'b1;
            scan_in_next.loc_idx = cell_index;
            scan_in_next.loc_len = len_ff;
            scan_in_next.room_ok = room_ok;
         end
      end
   end

   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      case (edit.op)
         ffa_pkg::EDIT_INSERT: begin
            if (cell_index == edit.index) begin
               start_in = edit.start;
               len_in   = edit.len;
            end else if (cell_index > edit.index) begin
               start_in = left_start;
               len_in   = left_len;
            end
         end
         ffa_pkg::EDIT_DELETE: begin
            if (cell_index >= edit.index) begin
               start_in = right_start;
               len_in   = right_len;
            end
         end
         ffa_pkg::EDIT_UPDATE: begin
            if (cell_index == edit.index) begin
               len_in = edit.len;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
      scan_ff  <= scan_in_next;
   end

   assign start_q  = start_ff;
   assign len_q    = len_ff;
   assign scan_out = scan_ff;

endmodule

@@ rtl/first_fit_arena_allocator_core.sv @@
// top level of the first-fit arena allocator: request sequencer, cell row
// and result register; uses ffa_pkg and ffa_cell

// First-fit allocator over a 64 KiB arena with a table of up to 64 blocks, each
// with a 24-byte header ahead of its data. Requests (allocate, free, reallocate)
// come in on the req_ stream and each gives exactly one result transfer on the
// rsp_ stream. The table lives in a row of cells, one block entry per cell in
// address order. A request is taken only when the sequencer is idle; its scan
// word then ripples through the row one cell per cycle. The next request can
// be accepted as soon as the result is registered, even while it still waits
// for rsp_tready; a reallocate that moves its block first drops the old entry
// in the drop state before the next accept. A result still waiting for
// rsp_tready when the next scan ends holds that scan until it leaves. Reset
// empties the table at once; no clearing pass is needed.
module first_fit_arena_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] req_type, [18:2] req_size, [34:19] data_address, rest zero
   input  logic [ffa_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] status, [18:3] result_address, [19] moved, [36:20] old_size, rest zero
   output logic [ffa_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   localparam int LAST = ffa_pkg::MAX_BLOCKS - 1;

   // sequencer state
   logic [1:0]                 state_ff, state_in;
   logic [ffa_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ffa_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ffa_pkg::IDX_W-1:0]  drop_idx_ff, drop_idx_in;
   logic [ffa_pkg::TYPE_W-1:0] kind_ff, kind_in;
   ffa_pkg::query_type         query_ff, query_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ffa_pkg::STAT_W-1:0]   status_ff, status_in;
   logic [ffa_pkg::START_W-1:0]  result_ff, result_in;
   logic                         moved_ff, moved_in;
   logic [ffa_pkg::LEN_W-1:0]    old_ff, old_in;

   // cell row
   logic [ffa_pkg::START_W-1:0]  start_q [ffa_pkg::MAX_BLOCKS];
   logic [ffa_pkg::LEN_W-1:0]    len_q   [ffa_pkg::MAX_BLOCKS];
   ffa_pkg::scan_type            scan_q  [ffa_pkg::MAX_BLOCKS];
   ffa_pkg::scan_type            scan_head;
   ffa_pkg::edit_type            edit;

   // input field unpacking
   logic [ffa_pkg::TYPE_W-1:0]   in_kind;
   logic [ffa_pkg::LEN_W-1:0]    in_size;
   logic [ffa_pkg::START_W-1:0]  in_addr;

   // decision
   ffa_pkg::scan_type            res;
   logic                         req_fire, scan_done, decide, tail_ok;
   logic [ffa_pkg::STAT_W-1:0]   pl_status;
   logic [ffa_pkg::IDX_W-1:0]    pl_slot;
   logic [ffa_pkg::START_W-1:0]  pl_pos, pl_addr;
   ffa_pkg::edit_type            dec_edit;
   logic [ffa_pkg::STAT_W-1:0]   dec_status;
   logic [ffa_pkg::START_W-1:0]  dec_result;
   logic                         dec_moved, dec_drop;
   logic [ffa_pkg::LEN_W-1:0]    dec_old;
   logic [ffa_pkg::IDX_W-1:0]    dec_drop_idx;

   assign in_kind = req_tdata[ffa_pkg::TYPE_W-1:0];
   assign in_size = req_tdata[ffa_pkg::TYPE_W +: ffa_pkg::LEN_W];
   assign in_addr = req_tdata[ffa_pkg::TYPE_W + ffa_pkg::LEN_W +: ffa_pkg::START_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign scan_done  = (state_ff == ST_SCAN) && (cnt_ff == ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS));
   // the result register must be free before a new result lands
   assign decide     = scan_done && (!rsp_valid_ff || rsp_tready);

   // scan word entering the first cell: nothing found, empty table ends at 0
   always_comb begin
      scan_head = '0;
   end

   genvar gi;
   generate
      for (gi = 0; gi < ffa_pkg::MAX_BLOCKS; gi++) begin : g_cell
         logic [ffa_pkg::START_W-1:0] l_start, r_start;
         logic [ffa_pkg::LEN_W-1:0]   l_len, r_len;
         ffa_pkg::scan_type           s_in;
         if (gi == 0) begin : g_first
            assign l_start = '0;
            assign l_len   = '0;
            assign s_in    = scan_head;
         end else begin : g_mid
            assign l_start = start_q[gi-1];
            assign l_len   = len_q[gi-1];
            assign s_in    = scan_q[gi-1];
         end
         if (gi == LAST) begin : g_last
            assign r_start = '0;
            assign r_len   = '0;
         end else begin : g_inner
            assign r_start = start_q[gi+1];
            assign r_len   = len_q[gi+1];
         end
         ffa_cell u_cell (
            .clock       (clock),
            .cell_index  (ffa_pkg::IDX_W'(gi)),
            .count       (count_ff),
            .query       (query_ff),
            .edit        (edit),
            .left_start  (l_start),
            .left_len    (l_len),
            .right_start (r_start),
            .right_len   (r_len),
            .scan_in     (s_in),
            .start_q     (start_q[gi]),
            .len_q       (len_q[gi]),
            .scan_out    (scan_q[gi])
         );
      end
   endgenerate

   assign res = scan_q[LAST];

   // first-fit placement from the settled scan word
   always_comb begin
      tail_ok   = (res.tail_end <= ffa_pkg::ARENA_END)
                  && ((ffa_pkg::ARENA_END - res.tail_end) >= query_ff.need);
      pl_status = ffa_pkg::ST_OK;
      pl_slot   = res.fit_slot;
      pl_pos    = res.fit_pos;
      if (query_ff.size == '0) begin
         pl_status = ffa_pkg::ST_ZERO_SIZE;
      end else if (count_ff >= ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS)) begin
         pl_status = ffa_pkg::ST_TABLE_FULL;
      end else if (!res.fit_hit) begin
         // no gap between blocks: try after the last block
         pl_slot = count_ff[ffa_pkg::IDX_W-1:0];
         pl_pos  = res.tail_end[ffa_pkg::START_W-1:0];
         if (!tail_ok) begin
            pl_status = ffa_pkg::ST_NO_SPACE;
         end
      end
      pl_addr = pl_pos + ffa_pkg::HEADER_ADDR;
   end

   // per-request outcome and table edit
   always_comb begin
      dec_edit       = '0;
      dec_edit.op    = ffa_pkg::EDIT_HOLD;
      dec_status     = ffa_pkg::ST_OK;
      dec_result     = '0;
      dec_moved      = 1'b0;
      dec_old        = '0;
      dec_drop       = 1'b0;
      dec_drop_idx   = res.loc_idx;
      case (kind_ff)
         ffa_pkg::REQ_ALLOC: begin
            dec_status = pl_status;
            if (pl_status == ffa_pkg::ST_OK) begin
               dec_edit.op    = ffa_pkg::EDIT_INSERT;
               dec_edit.index = pl_slot;
               dec_edit.start = pl_pos;
               dec_edit.len   = query_ff.size;
               dec_result     = pl_addr;
            end
         end
         ffa_pkg::REQ_FREE: begin
            // freeing null is a no-op
            if (query_ff.addr != '0) begin
               if (res.loc_hit) begin
                  dec_edit.op    = ffa_pkg::EDIT_DELETE;
                  dec_edit.index = res.loc_idx;
               end else begin
                  dec_status = ffa_pkg::ST_NOT_FOUND;
               end
            end
         end
         ffa_pkg::REQ_REALLOC: begin
            if (query_ff.addr == '0 || !res.loc_hit) begin
               dec_status = ffa_pkg::ST_NOT_FOUND;
            end else if (res.room_ok) begin
               // resize in place
               dec_edit.op    = ffa_pkg::EDIT_UPDATE;
               dec_edit.index = res.loc_idx;
               dec_edit.len   = query_ff.size;
               dec_result     = query_ff.addr;
            end else begin
               dec_status = pl_status;
               if (pl_status == ffa_pkg::ST_OK) begin
                  // insert the new block now, drop the old one next cycle
                  dec_edit.op    = ffa_pkg::EDIT_INSERT;
                  dec_edit.index = pl_slot;
                  dec_edit.start = pl_pos;
                  dec_edit.len   = query_ff.size;
                  dec_result     = pl_addr;
                  dec_moved      = 1'b1;
                  dec_old        = res.loc_len;
                  dec_drop       = 1'b1;
                  dec_drop_idx   = (pl_slot <= res.loc_idx)
                                   ? res.loc_idx + ffa_pkg::IDX_W'(1) : res.loc_idx;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      drop_idx_in  = drop_idx_ff;
      kind_in      = kind_ff;
      query_in     = query_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      moved_in     = moved_ff;
      old_in       = old_ff;
      edit         = '0;
      edit.op      = ffa_pkg::EDIT_HOLD;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in        = in_kind;
               query_in.size  = in_size;
               query_in.addr  = in_addr;
               query_in.need  = ffa_pkg::END_W'(in_size) + ffa_pkg::HEADER_END;
               cnt_in         = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               cnt_in = cnt_ff + ffa_pkg::CNT_W'(1);
            end else if (decide) begin
               edit         = dec_edit;
               rsp_valid_in = 1'b1;
               status_in    = dec_status;
               result_in    = dec_result;
               moved_in     = dec_moved;
               old_in       = dec_old;
               drop_idx_in  = dec_drop_idx;
               if (dec_edit.op == ffa_pkg::EDIT_INSERT) begin
                  count_in = count_ff + ffa_pkg::CNT_W'(1);
               end else if (dec_edit.op == ffa_pkg::EDIT_DELETE) begin
                  count_in = count_ff - ffa_pkg::CNT_W'(1);
               end
               state_in = dec_drop ? ST_DROP : ST_IDLE;
            end
         end
         ST_DROP: begin
            edit.op    = ffa_pkg::EDIT_DELETE;
            edit.index = drop_idx_ff;
            count_in   = count_ff - ffa_pkg::CNT_W'(1);
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_idx_ff <= drop_idx_in;
      kind_ff     <= kind_in;
      query_ff    <= query_in;
      status_ff   <= status_in;
      result_ff   <= result_in;
      moved_ff    <= moved_in;
      old_ff      <= old_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ffa_pkg::RSP_DATA_W'({old_ff, moved_ff, result_ff, status_ff});

   // table never holds more entries than cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS))
      else $error("block count beyond table size");

   // the table size changes only when a request completes or drops a moved block
   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == ST_SCAN || $past(state_ff) == ST_DROP))
      else $error("block count changed outside an edit");

   // a new result appears only out of a finished scan
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SCAN))
      else $error("result loaded without a scan");

   // the drop cycle always follows a loaded move result
   a_drop_has_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP) |-> (rsp_valid_ff && moved_ff))
      else $error("drop cycle without a moved result");

endmodule
